[src/bpg_pkg.sv]
package bpg_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned GestW  = 2;
  localparam int unsigned StateW = 3;

  // stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  // configuration register indexes
  localparam logic CfgLongPress   = 1'b0;
  localparam logic CfgDoubleWindow = 1'b1;

  // register reset values
  localparam logic [CfgW-1:0] LongPressRst    = 16'd1000;
  localparam logic [CfgW-1:0] DoubleWindowRst = 16'd400;

  // classifier states
  localparam logic [StateW-1:0] StIdle   = 3'd0;
  localparam logic [StateW-1:0] StFirst  = 3'd1;
  localparam logic [StateW-1:0] StWait   = 3'd2;
  localparam logic [StateW-1:0] StSecond = 3'd3;
  localparam logic [StateW-1:0] StLong   = 3'd4;

  // gesture codes
  localparam logic [GestW-1:0] GNone   = 2'd0;
  localparam logic [GestW-1:0] GSingle = 2'd1;
  localparam logic [GestW-1:0] GDouble = 2'd2;
  localparam logic [GestW-1:0] GLong   = 2'd3;

  // window position limits for the direction pick
  localparam logic [PosW-1:0] PosHigh = 8'd230;
  localparam logic [PosW-1:0] PosLow  = 8'd25;

endpackage

[src/button_press_gesture_classifier.sv]
// button press gesture classifier
//
// input stream (s_axis_*): one transfer per button poll, carrying the sampled
// level, a free-running millisecond timestamp and the rear window position.
// output stream (m_axis_*): exactly one transfer per poll, carrying the gesture
// decided on that poll (none, single, double, long) and, for a double press,
// the chosen window direction.
// config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 long press threshold,
// 1 double press window); the user writes only while idle, the block does not enforce it.
//
// a poll is captured in the input register, then classified and written to the
// output register, from which its result transfers to the receiver.
// throughput: one poll per cycle while the receiver takes results, with the
// state update (two 32-bit subtracts and compares) between the two registers.
// when the receiver stalls, the output register holds its result and the
// input register still takes one more poll; after that s_axis_tready drops
// until the output transfer completes.
// reset: state idle, timestamps zero, level not pressed, last direction up,
// thresholds 1000 ms and 400 ms, both registers empty.
module button_press_gesture_classifier
  import bpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // poll input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // button_level, now_ms, window_position, pad
  // gesture output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // gesture, window_up, pad
);

  // configuration registers
  logic [CfgW-1:0] long_ms_q, dbl_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q <= LongPressRst;
      dbl_ms_q  <= DoubleWindowRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgLongPress) long_ms_q <= cfg_data_i;
      else                           dbl_ms_q  <= cfg_data_i;
    end
  end

  // input register
  logic              in_vld_q;
  logic              lvl_q;
  logic [TimeW-1:0]  now_q;
  logic [PosW-1:0]   pos_q;

  // output register
  logic              out_vld_q;
  logic [GestW-1:0]  gest_q;
  logic              up_q;

  // classifier state
  logic [StateW-1:0] state_q, state_d;
  logic [TimeW-1:0]  press_t_q, press_t_d;
  logic [TimeW-1:0]  rel_t_q, rel_t_d;
  logic              prev_lvl_q;
  logic              last_up_q, last_up_d;
  logic [GestW-1:0]  gest_d;
  logic              up_d;

  logic advance;   // registered poll moves into the output register
  logic in_xfer;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lvl_q <= s_axis_tdata[0];
      now_q <= s_axis_tdata[TimeW:1];
      pos_q <= s_axis_tdata[TimeW+PosW:TimeW+1];
    end
  end

  // elapsed times, wrapping modulo 2^32
  logic [TimeW-1:0] since_press, since_rel;
  logic             rising, long_hit, window_over;

  assign since_press = now_q - press_t_q;
  assign since_rel   = now_q - rel_t_q;
  assign rising      = lvl_q && !prev_lvl_q;
  assign long_hit    = since_press >= {{(TimeW-CfgW){1'b0}}, long_ms_q};
  assign window_over = since_rel >= {{(TimeW-CfgW){1'b0}}, dbl_ms_q};

  always_comb begin
    state_d   = state_q;
    press_t_d = press_t_q;
    rel_t_d   = rel_t_q;
    last_up_d = last_up_q;
    gest_d    = GNone;
    up_d      = 1'b0;
    case (state_q)
      StFirst: begin
        if (!lvl_q) begin
          state_d = StWait;
          rel_t_d = now_q;
        end else if (long_hit) begin
          state_d = StLong;
          gest_d  = GLong;
        end
      end
      StWait: begin
        if (rising) begin
          state_d = StSecond;
        end else if (window_over) begin
          state_d = StIdle;
          gest_d  = GSingle;
        end
      end
      StSecond: begin
        if (!lvl_q) begin
          state_d = StIdle;
          gest_d  = GDouble;
          // near either end, roll away from it; otherwise alternate
          if (pos_q > PosHigh)     up_d = 1'b1;
          else if (pos_q < PosLow) up_d = 1'b0;
          else                     up_d = !last_up_q;
          last_up_d = up_d;
        end
      end
      StLong: begin
        if (!lvl_q) state_d = StIdle;
      end
      default: begin
        // idle, and unreachable codes behave as idle
        if (rising) begin
          state_d   = StFirst;
          press_t_d = now_q;
        end else begin
          state_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      press_t_q  <= '0;
      rel_t_q    <= '0;
      prev_lvl_q <= 1'b0;
      last_up_q  <= 1'b1;
    end else if (advance) begin
      state_q    <= state_d;
      press_t_q  <= press_t_d;
      rel_t_q    <= rel_t_d;
      prev_lvl_q <= lvl_q;
      last_up_q  <= last_up_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gest_q <= gest_d;
      up_q   <= up_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-GestW-1){1'b0}}, up_q, gest_q};

  // a direction is only ever reported with a double press
  a_up_only_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && up_q) |-> (gest_q == GDouble))
    else $error("window_up set outside a double press");

  // reaching the long threshold while held reports a long press and latches it
  a_long_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q == StFirst && lvl_q && long_hit)
      |=> (state_q == StLong && gest_q == GLong))
    else $error("long press not reported on threshold");

  // a held long press never reports again
  a_long_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q == StLong) |=> (gest_q == GNone))
    else $error("gesture reported while in long press");

  // input side only stalls when both registers are full and output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // state only moves when a poll is classified
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a poll");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bpg_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned RandomPolls = 1800;

  // one result transfer as the block packs it
  typedef struct packed {
    logic             window_up;
    logic [GestW-1:0] gesture;
  } gesture_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = CfgLongPress;
  logic [CfgW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // button_level, now_ms, window_position, pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // gesture, window_up, pad

  button_press_gesture_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the classifier, kept in step with accepted polls
  logic [CfgW-1:0]   long_ms    = LongPressRst;
  logic [CfgW-1:0]   window_ms  = DoubleWindowRst;
  logic [StateW-1:0] cls_state  = StIdle;
  logic [TimeW-1:0]  press_ms   = '0;
  logic [TimeW-1:0]  release_ms = '0;
  logic              prev_level = 1'b0;
  logic              last_up    = 1'b1;

  gesture_t    gesture_q[$];   // gestures still owed by the block, oldest first
  int unsigned poll_count    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 15;
  logic [TimeW-1:0] clock_ms = '0;   // running timestamp for generated polls

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // next-state and gesture of the classifier for one accepted poll
  function automatic void classify_poll(input logic level, input logic [TimeW-1:0] stamp,
                                        input logic [PosW-1:0] pos);
    logic             rising;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] waited;
    gesture_t         res;
    rising = level && !prev_level;
    held   = stamp - press_ms;    // wraps modulo 2^32
    waited = stamp - release_ms;
    res    = '{window_up: 1'b0, gesture: GNone};
    case (cls_state)
      StFirst: begin
        if (!level) begin
          cls_state  = StWait;
          release_ms = stamp;
        end else if (held >= TimeW'(long_ms)) begin
          cls_state   = StLong;
          res.gesture = GLong;
        end
      end
      StWait: begin
        if (rising) begin
          cls_state = StSecond;
        end else if (waited >= TimeW'(window_ms)) begin
          cls_state   = StIdle;
          res.gesture = GSingle;
        end
      end
      StSecond: begin
        if (!level) begin
          // direction: forced near the ends of travel, else toggled
          if (pos > PosHigh) res.window_up = 1'b1;
          else if (pos < PosLow) res.window_up = 1'b0;
          else res.window_up = !last_up;
          last_up     = res.window_up;
          res.gesture = GDouble;
          cls_state   = StIdle;
        end
      end
      StLong: begin
        if (!level) cls_state = StIdle;
      end
      default: begin
        if (rising) begin
          cls_state = StFirst;
          press_ms  = stamp;
        end else begin
          cls_state = StIdle;
        end
      end
    endcase
    prev_level = level;
    gesture_q.push_back(res);
  endfunction

  // offer one poll, with a random gap in front, and wait for its transfer
  task automatic send_poll(input logic level, input logic [TimeW-1:0] stamp,
                           input logic [PosW-1:0] pos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({pos, stamp, level});
    do @(posedge clk_i); while (!s_axis_tready);
    classify_poll(level, stamp, pos);
    poll_count++;
  endtask

  // stop sending and let every owed gesture come out
  task automatic wait_gestures_drained();
    s_axis_tvalid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgLongPress) long_ms = val;
    else window_ms = val;
  endtask

  // time step between polls: often short, often near a threshold,
  // now and then a big jump that may wrap the timestamp backwards
  function automatic logic [TimeW-1:0] next_step_ms();
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 40);
    if (roll < 75) begin
      near = ($urandom_range(0, 1) ? int'(long_ms) : int'(window_ms))
             + int'($urandom_range(0, 4)) - 2;
      return (near < 0) ? '0 : TimeW'(near);
    end
    if (roll < 92) return $urandom_range(0, 3000);
    return $urandom();
  endfunction

  // one generated poll; positions favor the direction limits
  task automatic poll(input logic level);
    logic [PosW-1:0] pos;
    case ($urandom_range(0, 9))
      0: pos = PosHigh;
      1: pos = PosHigh + 8'd1;
      2: pos = PosLow;
      3: pos = PosLow - 8'd1;
      4: pos = $urandom_range(0, 1) ? '1 : '0;
      default: pos = PosW'($urandom_range(0, 255));
    endcase
    clock_ms = clock_ms + next_step_ms();
    send_poll(level, clock_ms, pos);
  endtask

  task automatic press_and_release(input int unsigned max_holds);
    poll(1'b1);
    repeat ($urandom_range(0, max_holds)) poll(1'b1);
    poll(1'b0);
  endtask

  // one gesture-shaped burst of polls with random timing
  task automatic send_gesture();
    case ($urandom_range(0, 9))
      0, 1, 2: begin  // tap
        press_and_release(2);
        repeat ($urandom_range(1, 3)) poll(1'b0);
      end
      3, 4, 5: begin  // double tap
        press_and_release(1);
        repeat ($urandom_range(0, 1)) poll(1'b0);
        press_and_release(2);
        repeat ($urandom_range(1, 2)) poll(1'b0);
      end
      6, 7: begin     // hold
        press_and_release(4);
      end
      default: begin  // noise
        repeat ($urandom_range(1, 6)) poll(1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  function automatic logic [CfgW-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CfgW'($urandom_range(0, 20));
      3: return CfgW'($urandom_range(100, 2000));
      default: return CfgW'($urandom_range(0, 65535));
    endcase
  endfunction

  // directed gestures at reset thresholds (1000 ms hold, 400 ms window)
  task automatic test_reset_thresholds();
    logic [PosW-1:0] dbl_pos[4] = '{PosHigh + 8'd1, PosLow - 8'd1, PosHigh, PosLow};
    logic [TimeW-1:0] t;
    // single press across the timestamp wrap, window met exactly
    send_poll(1'b1, 32'hFFFF_FF80, '1);
    send_poll(1'b1, 32'hFFFF_FFF0, '1);
    send_poll(1'b0, 32'h0000_0010, '0);
    send_poll(1'b0, 32'h0000_0100, '0);
    send_poll(1'b0, 32'h0000_01A0, '0);
    // long press: one short of the threshold, at it, held on, released
    send_poll(1'b1, 32'h0000_1000, 8'd128);
    send_poll(1'b1, 32'h0000_1000 + 999, 8'd128);
    send_poll(1'b1, 32'h0000_1000 + 1000, 8'd128);
    send_poll(1'b1, 32'h0000_1000 + 5000, 8'd128);
    send_poll(1'b0, 32'h0000_1000 + 5100, 8'd128);
    // double presses on both sides of each direction limit
    t = 32'h0001_0000;
    foreach (dbl_pos[i]) begin
      send_poll(1'b1, t,       dbl_pos[i]);
      send_poll(1'b0, t + 50,  dbl_pos[i]);
      send_poll(1'b1, t + 100, dbl_pos[i]);
      send_poll(1'b0, t + 150, dbl_pos[i]);
      t = t + 1000;
    end
    clock_ms = t;
  endtask

  // zero thresholds: first held poll is long, first idle poll ends the wait
  task automatic test_zero_thresholds();
    wait_gestures_drained();
    write_config(CfgLongPress, '0);
    write_config(CfgDoubleWindow, '0);
    send_poll(1'b1, clock_ms, 8'd100);
    send_poll(1'b1, clock_ms, 8'd100);
    send_poll(1'b0, clock_ms, 8'd100);
    send_poll(1'b1, clock_ms + 1, 8'd100);
    send_poll(1'b0, clock_ms + 1, 8'd100);
    send_poll(1'b0, clock_ms + 1, 8'd100);
    send_poll(1'b1, clock_ms + 2, 8'd100);
    send_poll(1'b0, clock_ms + 2, 8'd100);
    send_poll(1'b1, clock_ms + 2, 8'd100);
    send_poll(1'b0, clock_ms + 2, 8'd100);
    clock_ms = clock_ms + 2;
  endtask

  // random gestures, thresholds changed between phases while drained
  task automatic test_random_gestures();
    int unsigned target;
    int unsigned phase;
    target = poll_count + RandomPolls;
    phase  = 0;
    while (poll_count < target) begin
      wait_gestures_drained();
      case (phase)
        0: begin
          write_config(CfgLongPress, '1);
          write_config(CfgDoubleWindow, '1);
        end
        1: begin
          write_config(CfgLongPress, '0);
          write_config(CfgDoubleWindow, '1);
        end
        default: begin
          write_config(CfgLongPress, pick_threshold());
          write_config(CfgDoubleWindow, pick_threshold());
        end
      endcase
      // one phase runs back to back on both sides
      send_idle_pct = (phase == 3) ? 0 : 15;
      recv_idle_pct = (phase == 3) ? 0 : 15;
      repeat (60) begin
        if (poll_count < target) send_gesture();
      end
      phase++;
    end
    send_idle_pct = 15;
    recv_idle_pct = 15;
  endtask

  // output side: random backpressure, each transfer checked against the oldest gesture
  always @(posedge clk_i) begin : check_gestures
    gesture_t want;
    gesture_t got;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = gesture_t'(m_axis_tdata[GestW:0]);
        if (gesture_q.size() == 0) begin
          $error("unexpected gesture transfer: gesture %0d window_up %0d",
                 got.gesture, got.window_up);
          fail_count++;
        end else begin
          want = gesture_q.pop_front();
          if (got.gesture !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, got.gesture);
            fail_count++;
          end
          if (got.window_up !== want.window_up) begin
            $error("window_up: expected %0d, got %0d", want.window_up, got.window_up);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_thresholds();
    test_zero_thresholds();
    test_random_gestures();
    wait_gestures_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
